// ===== hdl/uart_dual_ring_buffer_unit_assert.svh =====
// assertion macros of the serial port ring buffer, used by the back end
`ifndef UART_DUAL_RING_BUFFER_UNIT_ASSERT_SVH
`define UART_DUAL_RING_BUFFER_UNIT_ASSERT_SVH

// check a property on every clock edge outside reset
`define UARTRB_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check a property on every clock edge, reset included
`define UARTRB_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/uartrb_pkg.sv =====
// types, constants and helpers of the serial port ring buffer
package uartrb_pkg;

   localparam int RING_DEPTH = 64;
   localparam int PTR_W      = $clog2(RING_DEPTH);
   localparam int CNT_W      = 6;
   localparam int CNT_MAX    = 63;
   localparam int QDEPTH     = 2;
   localparam int QIDX_W     = 1;
   localparam int QCNT_W     = 2;

   // receive count reported when the receive ring is full
   localparam logic [CNT_W-1:0] RX_FULL_CNT =
      CNT_W'((RING_DEPTH - 1 > CNT_MAX) ? CNT_MAX : RING_DEPTH - 1);

   typedef enum logic [1:0] {
      EV_HOST_WRITE = 2'd0,
      EV_HOST_READ  = 2'd1,
      EV_RX_BYTE    = 2'd2,
      EV_TX_EMPTY   = 2'd3
   } event_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] data_byte;
   } req_item_type;

   typedef struct packed {
      logic             write_accepted;
      logic             read_valid;
      logic [7:0]       read_data;
      logic             rx_dropped;
      logic             tx_valid;
      logic [7:0]       tx_byte;
      logic             tx_irq_enabled;
      logic [CNT_W-1:0] rx_count;
   } rsp_item_type;

   // classified item as held in the queue
   typedef struct packed {
      event_type  ev;
      logic [7:0] data;
   } cmd_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } link_type;

   // advance a ring pointer with wrap
   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(RING_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   // fill count of a ring, saturated to the count width
   function automatic logic [CNT_W-1:0] ring_fill(input logic [PTR_W-1:0] w,
                                                  input logic [PTR_W-1:0] r);
      logic [PTR_W:0]   diff;
      logic [31:0]      wide;
      logic [CNT_W-1:0] res;
      if (w >= r) begin
         diff = {1'b0, w} - {1'b0, r};
      end else begin
         diff = {1'b0, w} + (PTR_W+1)'(RING_DEPTH) - {1'b0, r};
      end
      wide = 32'(diff);
      if (wide > 32'(CNT_MAX)) begin
         res = CNT_W'(CNT_MAX);
      end else begin
         res = wide[CNT_W-1:0];
      end
      return res;
   endfunction

endpackage

// ===== hdl/uartrb_front.sv =====
// front end: takes items, classifies them and queues them for the back end
module uartrb_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  uartrb_pkg::req_item_type req_item,
   output uartrb_pkg::link_type     link
);

   uartrb_pkg::cmd_type                 slot_ff [uartrb_pkg::QDEPTH];
   logic [uartrb_pkg::QIDX_W-1:0]       wr_idx_ff, wr_idx_in;
   logic [uartrb_pkg::QIDX_W-1:0]       rd_idx_ff, rd_idx_in;
   logic [uartrb_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                                push;
   logic                                pop;
   uartrb_pkg::cmd_type                 cmd;

   // classify the incoming item
   always_comb begin
      cmd.ev   = uartrb_pkg::event_type'(req_item.req_type);
      cmd.data = req_item.data_byte;
   end

   // handshake: back end drains the head every cycle it is valid
   assign busy = (count_ff == uartrb_pkg::QCNT_W'(uartrb_pkg::QDEPTH));
   assign push = start && !busy;
   assign pop  = (count_ff != '0);

   assign link.valid = pop;
   assign link.cmd   = slot_ff[rd_idx_ff];

   // queue index and count update
   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      count_in  = count_ff;
      if (push) begin
         wr_idx_in = wr_idx_ff + uartrb_pkg::QIDX_W'(1);
      end
      if (pop) begin
         rd_idx_in = rd_idx_ff + uartrb_pkg::QIDX_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + uartrb_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - uartrb_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_idx_ff] <= cmd;
      end
   end

endmodule

// ===== hdl/uartrb_back.sv =====
// back end: ring pointers, ring memories and result register
`include "uart_dual_ring_buffer_unit_assert.svh"

module uartrb_back (
   input  logic                     clock,
   input  logic                     reset,
   input  uartrb_pkg::link_type     link,
   output logic                     rsp_strobe,
   output uartrb_pkg::rsp_item_type rsp_item
);

   logic [7:0]                   tx_store_ff [uartrb_pkg::RING_DEPTH];
   logic [7:0]                   rx_store_ff [uartrb_pkg::RING_DEPTH];
   logic [uartrb_pkg::PTR_W-1:0] tx_wr_ptr_ff, tx_wr_ptr_in;
   logic [uartrb_pkg::PTR_W-1:0] tx_rd_ptr_ff, tx_rd_ptr_in;
   logic [uartrb_pkg::PTR_W-1:0] rx_wr_ptr_ff, rx_wr_ptr_in;
   logic [uartrb_pkg::PTR_W-1:0] rx_rd_ptr_ff, rx_rd_ptr_in;
   logic                         irq_en_ff, irq_en_in;
   logic [uartrb_pkg::PTR_W-1:0] tx_nxt;
   logic [uartrb_pkg::PTR_W-1:0] rx_nxt;
   logic                         tx_we, tx_re, rx_we, rx_re;
   logic                         wr_ok, rd_ok, dropped, tx_ok;

   logic                         valid_ff;
   logic                         wr_ok_ff, rd_ok_ff, dropped_ff, tx_ok_ff;
   logic [7:0]                   tx_data_ff, rx_data_ff;
   logic [uartrb_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   assign tx_nxt = uartrb_pkg::ring_next(tx_wr_ptr_ff);
   assign rx_nxt = uartrb_pkg::ring_next(rx_wr_ptr_ff);

   // carry out the item at the queue head
   always_comb begin
      tx_wr_ptr_in = tx_wr_ptr_ff;
      tx_rd_ptr_in = tx_rd_ptr_ff;
      rx_wr_ptr_in = rx_wr_ptr_ff;
      rx_rd_ptr_in = rx_rd_ptr_ff;
      irq_en_in    = irq_en_ff;
      tx_we        = 1'b0;
      tx_re        = 1'b0;
      rx_we        = 1'b0;
      rx_re        = 1'b0;
      wr_ok        = 1'b0;
      rd_ok        = 1'b0;
      dropped      = 1'b0;
      tx_ok        = 1'b0;
      if (link.valid) begin
         case (link.cmd.ev)
            uartrb_pkg::EV_HOST_WRITE: begin
               if (tx_nxt != tx_rd_ptr_ff) begin
                  tx_we        = 1'b1;
                  tx_wr_ptr_in = tx_nxt;
                  irq_en_in    = 1'b1;
                  wr_ok        = 1'b1;
               end
            end
            uartrb_pkg::EV_HOST_READ: begin
               if (rx_wr_ptr_ff != rx_rd_ptr_ff) begin
                  rx_re        = 1'b1;
                  rx_rd_ptr_in = uartrb_pkg::ring_next(rx_rd_ptr_ff);
                  rd_ok        = 1'b1;
               end
            end
            uartrb_pkg::EV_RX_BYTE: begin
               if (rx_nxt != rx_rd_ptr_ff) begin
                  rx_we        = 1'b1;
                  rx_wr_ptr_in = rx_nxt;
               end else begin
                  dropped = 1'b1;
               end
            end
            uartrb_pkg::EV_TX_EMPTY: begin
               if (irq_en_ff) begin
                  if (tx_wr_ptr_ff != tx_rd_ptr_ff) begin
                     tx_re        = 1'b1;
                     tx_rd_ptr_in = uartrb_pkg::ring_next(tx_rd_ptr_ff);
                     tx_ok        = 1'b1;
                  end else begin
                     irq_en_in = 1'b0;
                  end
               end
            end
            default: begin
               irq_en_in = irq_en_ff;
            end
         endcase
      end
   end

   // receive fill after this item
   assign cnt_in = uartrb_pkg::ring_fill(rx_wr_ptr_in, rx_rd_ptr_in);

   // pointer, enable and result control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_wr_ptr_ff <= '0;
         tx_rd_ptr_ff <= '0;
         rx_wr_ptr_ff <= '0;
         rx_rd_ptr_ff <= '0;
         irq_en_ff    <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         tx_wr_ptr_ff <= tx_wr_ptr_in;
         tx_rd_ptr_ff <= tx_rd_ptr_in;
         rx_wr_ptr_ff <= rx_wr_ptr_in;
         rx_rd_ptr_ff <= rx_rd_ptr_in;
         irq_en_ff    <= irq_en_in;
         valid_ff     <= link.valid;
      end
   end

   // result payload registers
   always_ff @(posedge clock) begin
      wr_ok_ff   <= wr_ok;
      rd_ok_ff   <= rd_ok;
      dropped_ff <= dropped;
      tx_ok_ff   <= tx_ok;
      cnt_ff     <= cnt_in;
   end

   // transmit ring memory
   always_ff @(posedge clock) begin
      if (tx_we) begin
         tx_store_ff[tx_wr_ptr_ff] <= link.cmd.data;
      end
      if (tx_re) begin
         tx_data_ff <= tx_store_ff[tx_rd_ptr_ff];
      end
   end

   // receive ring memory
   always_ff @(posedge clock) begin
      if (rx_we) begin
         rx_store_ff[rx_wr_ptr_ff] <= link.cmd.data;
      end
      if (rx_re) begin
         rx_data_ff <= rx_store_ff[rx_rd_ptr_ff];
      end
   end

   // result item
   assign rsp_strobe              = valid_ff;
   assign rsp_item.write_accepted = wr_ok_ff;
   assign rsp_item.read_valid     = rd_ok_ff;
   assign rsp_item.read_data      = rd_ok_ff ? rx_data_ff : 8'h00;
   assign rsp_item.rx_dropped     = dropped_ff;
   assign rsp_item.tx_valid       = tx_ok_ff;
   assign rsp_item.tx_byte        = tx_ok_ff ? tx_data_ff : 8'h00;
   assign rsp_item.tx_irq_enabled = irq_en_ff;
   assign rsp_item.rx_count       = cnt_ff;

   // every popped item yields a result in the next cycle
   `UARTRB_ASSERT(a_pop_gives_rsp, clock, reset, link.valid |=> rsp_strobe,
                  "popped item produced no result")
   // at most one event flag per result
   `UARTRB_ASSERT(a_one_flag, clock, reset,
                  rsp_strobe |-> $onehot0({wr_ok_ff, rd_ok_ff, dropped_ff, tx_ok_ff}),
                  "more than one event flag in a result")
   // an accepted write leaves the interrupt enable set
   `UARTRB_ASSERT(a_write_sets_irq, clock, reset,
                  (rsp_strobe && wr_ok_ff) |-> irq_en_ff,
                  "accepted write without interrupt enable")
   // a drop only happens with the receive ring full
   `UARTRB_ASSERT(a_drop_when_full, clock, reset,
                  (rsp_strobe && dropped_ff) |-> (cnt_ff == uartrb_pkg::RX_FULL_CNT),
                  "receive byte dropped with room left")

endmodule

// ===== hdl/uart_dual_ring_buffer_unit.sv =====
// top level of the serial port transmit and receive ring buffer
//
// Input channel: an item (event kind and data byte) is taken at a rising
// edge with start high and busy low. Kinds: host write, host read, byte
// received, transmit register empty.
// Result channel: one result per item, shown on rsp_item for exactly one
// cycle with rsp_strobe high; the receiver takes it at the end of that cycle
// and cannot hold it off.
// Path: an item taken enters a two-entry queue, is executed by the back end
// from the queue head (pointer update, ring memory access) and its result is
// held in the back end's result registers while it is shown.
// Throughput: one item per cycle; the back end drains the queue head every
// cycle, so busy stays low in steady operation.
// Each ring holds RING_DEPTH-1 bytes; rx_count saturates at 63.
// Reset: clears all ring pointers, the transmit interrupt enable and the
// queue. Ring contents are not cleared and need no clearing pass.
module uart_dual_ring_buffer_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  uartrb_pkg::req_item_type req_item,
   output logic                     rsp_strobe,
   output uartrb_pkg::rsp_item_type rsp_item
);

   uartrb_pkg::link_type link;

   // accept and classify
   uartrb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .link     (link)
   );

   // execute and report
   uartrb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .link       (link),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

// ===== sim/uart_dual_ring_buffer_unit_tb.sv =====
// self-checking testbench of the serial port transmit and receive ring buffer
`timescale 1ns / 100ps

module uart_dual_ring_buffer_unit_tb;

   localparam int RANDOM_ITEMS = 1300;
   localparam int CYCLE_LIMIT  = 100000;
   localparam int DRAIN_CYCLES = 8;
   localparam int REPORT_MAX   = 10;

   // traffic mix of one random segment
   typedef enum int {
      TRAFFIC_MIXED,
      TRAFFIC_FILL_TX,
      TRAFFIC_FILL_RX,
      TRAFFIC_FILL_BOTH,
      TRAFFIC_DRAIN
   } traffic_mode_type;

   // one row of the directed table; want is used only where typed is set
   typedef struct packed {
      uartrb_pkg::req_item_type req;
      logic                     typed;
      uartrb_pkg::rsp_item_type want;
   } directed_row_type;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   uartrb_pkg::req_item_type req_item;
   logic                     rsp_strobe;
   uartrb_pkg::rsp_item_type rsp_item;

   // shadow copy of both rings
   logic [7:0]                   tx_ring [uartrb_pkg::RING_DEPTH];
   logic [7:0]                   rx_ring [uartrb_pkg::RING_DEPTH];
   logic [uartrb_pkg::PTR_W-1:0] tx_wr_ptr;
   logic [uartrb_pkg::PTR_W-1:0] tx_rd_ptr;
   logic [uartrb_pkg::PTR_W-1:0] rx_wr_ptr;
   logic [uartrb_pkg::PTR_W-1:0] rx_rd_ptr;
   logic                         tx_irq_en;

   uartrb_pkg::rsp_item_type expected_rsp_q [$];
   directed_row_type         directed_rows [$];

   int unsigned cycle_count;
   int unsigned mismatch_count;
   int unsigned unexpected_count;
   int unsigned results_checked;
   int unsigned tx_full_hits;
   int unsigned rx_full_hits;
   int unsigned bytes_sent;
   int unsigned bytes_read;

   uart_dual_ring_buffer_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // clock
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due",
                  cycle_count, expected_rsp_q.size());
         $display("[uart_dual_ring_buffer_unit] ERROR");
         $finish;
      end
   end

   // ring pointer advance with wrap
   function automatic logic [uartrb_pkg::PTR_W-1:0] ptr_after(
      input logic [uartrb_pkg::PTR_W-1:0] p);
      return (int'(p) == uartrb_pkg::RING_DEPTH - 1) ? '0 : p + 1'b1;
   endfunction

   // apply one event to the shadow rings and form its result
   function automatic uartrb_pkg::rsp_item_type ring_buffer_step(
      input uartrb_pkg::req_item_type it);
      uartrb_pkg::rsp_item_type     r;
      logic [uartrb_pkg::PTR_W-1:0] nxt;
      int                           fill;
      r = '0;
      case (it.req_type)
         uartrb_pkg::EV_HOST_WRITE: begin
            nxt = ptr_after(tx_wr_ptr);
            if (nxt != tx_rd_ptr) begin
               tx_ring[tx_wr_ptr] = it.data_byte;
               tx_wr_ptr          = nxt;
               tx_irq_en          = 1'b1;
               r.write_accepted   = 1'b1;
            end else begin
               tx_full_hits++;
            end
         end
         uartrb_pkg::EV_HOST_READ: begin
            if (rx_wr_ptr != rx_rd_ptr) begin
               r.read_data  = rx_ring[rx_rd_ptr];
               r.read_valid = 1'b1;
               rx_rd_ptr    = ptr_after(rx_rd_ptr);
               bytes_read++;
            end
         end
         uartrb_pkg::EV_RX_BYTE: begin
            nxt = ptr_after(rx_wr_ptr);
            if (nxt != rx_rd_ptr) begin
               rx_ring[rx_wr_ptr] = it.data_byte;
               rx_wr_ptr          = nxt;
            end else begin
               r.rx_dropped = 1'b1;
               rx_full_hits++;
            end
         end
         default: begin
            // transmit register empty only matters with the enable set
            if (tx_irq_en) begin
               if (tx_wr_ptr != tx_rd_ptr) begin
                  r.tx_byte  = tx_ring[tx_rd_ptr];
                  r.tx_valid = 1'b1;
                  tx_rd_ptr  = ptr_after(tx_rd_ptr);
                  bytes_sent++;
               end else begin
                  tx_irq_en = 1'b0;
               end
            end
         end
      endcase
      fill = (int'(rx_wr_ptr) + uartrb_pkg::RING_DEPTH - int'(rx_rd_ptr))
             % uartrb_pkg::RING_DEPTH;
      if (fill > uartrb_pkg::CNT_MAX) fill = uartrb_pkg::CNT_MAX;
      r.tx_irq_enabled = tx_irq_en;
      r.rx_count       = uartrb_pkg::CNT_W'(fill);
      return r;
   endfunction

   // compare one field of a result
   task automatic check_field(input string fname, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_MAX) begin
            $display("result %0d field %s: expected %0h, got %0h",
                     results_checked, fname, want, got);
         end
      end
   endtask

   // result checker
   always @(posedge clock) begin
      uartrb_pkg::rsp_item_type want;
      if (!reset && rsp_strobe) begin
         if (expected_rsp_q.size() == 0) begin
            unexpected_count++;
            if (unexpected_count <= REPORT_MAX) begin
               $display("result with no item outstanding: %p", rsp_item);
            end
         end else begin
            want = expected_rsp_q.pop_front();
            check_field("write_accepted", 8'(rsp_item.write_accepted),
                        8'(want.write_accepted));
            check_field("read_valid", 8'(rsp_item.read_valid), 8'(want.read_valid));
            check_field("read_data", rsp_item.read_data, want.read_data);
            check_field("rx_dropped", 8'(rsp_item.rx_dropped), 8'(want.rx_dropped));
            check_field("tx_valid", 8'(rsp_item.tx_valid), 8'(want.tx_valid));
            check_field("tx_byte", rsp_item.tx_byte, want.tx_byte);
            check_field("tx_irq_enabled", 8'(rsp_item.tx_irq_enabled),
                        8'(want.tx_irq_enabled));
            check_field("rx_count", 8'(rsp_item.rx_count), 8'(want.rx_count));
            results_checked++;
         end
      end
   end

   // append one row to the directed table
   task automatic add_row(input uartrb_pkg::event_type kind, input logic [7:0] data,
                          input logic typed, input uartrb_pkg::rsp_item_type want);
      directed_row_type row;
      row.req.req_type  = kind;
      row.req.data_byte = data;
      row.typed         = typed;
      row.want          = want;
      directed_rows.push_back(row);
   endtask

   // stimulus
   initial begin
      uartrb_pkg::rsp_item_type zero_rsp;
      uartrb_pkg::rsp_item_type first_write_rsp;
      uartrb_pkg::rsp_item_type want;
      uartrb_pkg::req_item_type it;
      traffic_mode_type         mode;
      uartrb_pkg::event_type    kind;
      int                       total;
      int                       seg_left;
      int                       burst_left;
      int                       gap;
      int                       roll;
      int                       leftover;

      reset            = 1'b1;
      start            = 1'b0;
      req_item         = '0;
      cycle_count      = 0;
      mismatch_count   = 0;
      unexpected_count = 0;
      results_checked  = 0;
      tx_full_hits     = 0;
      rx_full_hits     = 0;
      bytes_sent       = 0;
      bytes_read       = 0;
      tx_wr_ptr        = '0;
      tx_rd_ptr        = '0;
      rx_wr_ptr        = '0;
      rx_rd_ptr        = '0;
      tx_irq_en        = 1'b0;

      zero_rsp                       = '0;
      first_write_rsp                = '0;
      first_write_rsp.write_accepted = 1'b1;
      first_write_rsp.tx_irq_enabled = 1'b1;

      // directed part: empty rings, extremes of the byte, enable handling
      add_row(uartrb_pkg::EV_HOST_READ,  8'hA5, 1'b1, zero_rsp);
      add_row(uartrb_pkg::EV_TX_EMPTY,   8'hFF, 1'b1, zero_rsp);
      add_row(uartrb_pkg::EV_RX_BYTE,    8'h00, 1'b0, zero_rsp);
      add_row(uartrb_pkg::EV_RX_BYTE,    8'hFF, 1'b0, zero_rsp);
      add_row(uartrb_pkg::EV_RX_BYTE,    8'h5A, 1'b0, zero_rsp);
      add_row(uartrb_pkg::EV_HOST_READ,  8'h00, 1'b0, zero_rsp);
      add_row(uartrb_pkg::EV_HOST_READ,  8'hFF, 1'b0, zero_rsp);
      add_row(uartrb_pkg::EV_HOST_READ,  8'h12, 1'b0, zero_rsp);
      add_row(uartrb_pkg::EV_HOST_READ,  8'h34, 1'b1, zero_rsp);
      add_row(uartrb_pkg::EV_HOST_WRITE, 8'h00, 1'b1, first_write_rsp);
      add_row(uartrb_pkg::EV_HOST_WRITE, 8'hFF, 1'b0, zero_rsp);
      add_row(uartrb_pkg::EV_HOST_WRITE, 8'h81, 1'b0, zero_rsp);
      add_row(uartrb_pkg::EV_TX_EMPTY,   8'h00, 1'b0, zero_rsp);
      add_row(uartrb_pkg::EV_TX_EMPTY,   8'h7E, 1'b0, zero_rsp);
      add_row(uartrb_pkg::EV_TX_EMPTY,   8'hE7, 1'b0, zero_rsp);
      add_row(uartrb_pkg::EV_TX_EMPTY,   8'h55, 1'b0, zero_rsp);
      add_row(uartrb_pkg::EV_TX_EMPTY,   8'hAA, 1'b1, zero_rsp);
      add_row(uartrb_pkg::EV_RX_BYTE,    8'hC3, 1'b0, zero_rsp);
      add_row(uartrb_pkg::EV_HOST_WRITE, 8'h3C, 1'b0, zero_rsp);
      add_row(uartrb_pkg::EV_HOST_READ,  8'h99, 1'b0, zero_rsp);
      add_row(uartrb_pkg::EV_TX_EMPTY,   8'h66, 1'b0, zero_rsp);
      add_row(uartrb_pkg::EV_TX_EMPTY,   8'h01, 1'b0, zero_rsp);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      total      = directed_rows.size() + RANDOM_ITEMS;
      seg_left   = 0;
      mode       = TRAFFIC_MIXED;
      burst_left = $urandom_range(1, 12);

      for (int idx = 0; idx < total; idx++) begin
         // next item: directed row first, then segments of biased traffic
         if (idx < directed_rows.size()) begin
            it = directed_rows[idx].req;
         end else begin
            if (seg_left == 0) begin
               mode     = traffic_mode_type'($urandom_range(0, 4));
               seg_left = $urandom_range(40, 200);
            end
            seg_left--;
            roll = $urandom_range(0, 99);
            case (mode)
               TRAFFIC_FILL_TX:
                  kind = (roll < 80) ? uartrb_pkg::EV_HOST_WRITE :
                         uartrb_pkg::event_type'($urandom_range(0, 3));
               TRAFFIC_FILL_RX:
                  kind = (roll < 80) ? uartrb_pkg::EV_RX_BYTE :
                         uartrb_pkg::event_type'($urandom_range(0, 3));
               TRAFFIC_FILL_BOTH:
                  kind = (roll < 40) ? uartrb_pkg::EV_HOST_WRITE :
                         (roll < 80) ? uartrb_pkg::EV_RX_BYTE :
                         uartrb_pkg::event_type'($urandom_range(0, 3));
               TRAFFIC_DRAIN:
                  kind = (roll < 45) ? uartrb_pkg::EV_HOST_READ :
                         (roll < 90) ? uartrb_pkg::EV_TX_EMPTY :
                         uartrb_pkg::event_type'($urandom_range(0, 3));
               default:
                  kind = uartrb_pkg::event_type'($urandom_range(0, 3));
            endcase
            it.req_type  = kind;
            it.data_byte = 8'($urandom_range(0, 255));
         end

         // offer the item and wait for it to be taken
         start    <= 1'b1;
         req_item <= it;
         @(posedge clock);
         while (busy) @(posedge clock);

         want = ring_buffer_step(it);
         if (idx < directed_rows.size() && directed_rows[idx].typed) begin
            want = directed_rows[idx].want;
         end
         expected_rsp_q.push_back(want);

         // bursts of items, usually separated by an idle gap
         if (burst_left > 0) burst_left--;
         if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 12);
            if (gap > 0) begin
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
      start <= 1'b0;

      // let the pipeline drain and catch stray results
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      leftover = expected_rsp_q.size();

      $display("%0d items sent, %0d results checked, %0d field mismatches, %0d stray results",
               total, results_checked, mismatch_count, unexpected_count);
      $display("writes refused on full ring %0d, receive drops %0d, bytes sent %0d, read %0d",
               tx_full_hits, rx_full_hits, bytes_sent, bytes_read);
      if (mismatch_count == 0 && unexpected_count == 0 && leftover == 0) begin
         $display("[uart_dual_ring_buffer_unit] OK");
      end else begin
         $display("[uart_dual_ring_buffer_unit] ERROR");
      end
      $finish;
   end

endmodule
